FILE: rtl/a2hke_pkg.sv
// ----------------------------------------------------------------------------
// a2hke_pkg
// Shared types, usage codes and the US-layout key mapping for the
// text-to-keystroke encoder.
// ----------------------------------------------------------------------------
package a2hke_pkg;

    localparam logic [7:0] USAGE_A          = 8'h04;
    localparam logic [7:0] USAGE_1          = 8'h1E;
    localparam logic [7:0] USAGE_0          = 8'h27;
    localparam logic [7:0] USAGE_ENTER      = 8'h28;
    localparam logic [7:0] USAGE_TAB        = 8'h2B;
    localparam logic [7:0] USAGE_SPACE      = 8'h2C;
    localparam logic [7:0] USAGE_MINUS      = 8'h2D;
    localparam logic [7:0] USAGE_SLASH      = 8'h38;
    localparam logic [7:0] USAGE_LEFT_SHIFT = 8'hE1;
    localparam logic [7:0] USAGE_NONE       = 8'h00;

    localparam logic [7:0] CHR_LF = 8'h0A;
    localparam logic [7:0] CHR_CR = 8'h0D;

    localparam int STATE_WIDTH = 1;
    localparam int STATE_DEPTH = 1;

    typedef struct packed {
        logic [7:0] usage;
        logic       shifted;
    } t_map;

    function automatic t_map map_byte(input logic [7:0] c);
        t_map m;
        m.usage   = USAGE_NONE;
        m.shifted = 1'b0;
        priority if (c >= 8'h61 && c <= 8'h7A) begin
            m.usage = USAGE_A + (c - 8'h61);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            m.usage   = USAGE_A + (c - 8'h41);
            m.shifted = 1'b1;
        end else if (c >= 8'h31 && c <= 8'h39) begin
            m.usage = USAGE_1 + (c - 8'h31);
        end else begin
            unique case (c)
                8'h30:           m.usage = USAGE_0;
                CHR_LF, CHR_CR:  m.usage = USAGE_ENTER;
                8'h09:           m.usage = USAGE_TAB;
                8'h20:           m.usage = USAGE_SPACE;
                8'h2D:           m.usage = USAGE_MINUS;
                8'h3D:           m.usage = 8'h2E;
                8'h5B:           m.usage = 8'h2F;
                8'h5D:           m.usage = 8'h30;
                8'h5C:           m.usage = 8'h31;
                8'h3B:           m.usage = 8'h33;
                8'h27:           m.usage = 8'h34;
                8'h60:           m.usage = 8'h35;
                8'h2C:           m.usage = 8'h36;
                8'h2E:           m.usage = 8'h37;
                8'h2F:           m.usage = USAGE_SLASH;
                8'h5F: begin m.usage = USAGE_MINUS; m.shifted = 1'b1; end
                8'h2B: begin m.usage = 8'h2E;       m.shifted = 1'b1; end
                8'h7B: begin m.usage = 8'h2F;       m.shifted = 1'b1; end
                8'h7D: begin m.usage = 8'h30;       m.shifted = 1'b1; end
                8'h7C: begin m.usage = 8'h31;       m.shifted = 1'b1; end
                8'h3A: begin m.usage = 8'h33;       m.shifted = 1'b1; end
                8'h22: begin m.usage = 8'h34;       m.shifted = 1'b1; end
                8'h7E: begin m.usage = 8'h35;       m.shifted = 1'b1; end
                8'h3C: begin m.usage = 8'h36;       m.shifted = 1'b1; end
                8'h3E: begin m.usage = 8'h37;       m.shifted = 1'b1; end
                8'h3F: begin m.usage = USAGE_SLASH; m.shifted = 1'b1; end
                8'h21: begin m.usage = USAGE_1;     m.shifted = 1'b1; end
                8'h40: begin m.usage = 8'h1F;       m.shifted = 1'b1; end
                8'h23: begin m.usage = 8'h20;       m.shifted = 1'b1; end
                8'h24: begin m.usage = 8'h21;       m.shifted = 1'b1; end
                8'h25: begin m.usage = 8'h22;       m.shifted = 1'b1; end
                8'h5E: begin m.usage = 8'h23;       m.shifted = 1'b1; end
                8'h26: begin m.usage = 8'h24;       m.shifted = 1'b1; end
                8'h2A: begin m.usage = 8'h25;       m.shifted = 1'b1; end
                8'h28: begin m.usage = 8'h26;       m.shifted = 1'b1; end
                8'h29: begin m.usage = USAGE_0;     m.shifted = 1'b1; end
                default: begin
                    m.usage   = USAGE_NONE;
                    m.shifted = 1'b0;
                end
            endcase
        end
        return m;
    endfunction

endpackage

FILE: rtl/a2hke_ram.sv
// ----------------------------------------------------------------------------
// a2hke_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module a2hke_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ascii_to_hid_keystroke_encoder_unit.sv
// ----------------------------------------------------------------------------
// ascii_to_hid_keystroke_encoder_unit
// Turns text bytes into US-layout HID keyboard press/release events.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one text byte per transfer on s_axis_tdata.
//   Master channel gives one key event per transfer: tdata is the usage code,
//   tuser[0] is key_down, tuser[1] is bad_character, tlast marks the final
//   event of a byte.
//   A plain key gives press then release (2 transfers), a shifted key is
//   wrapped in Left Shift press/release (4 transfers), an unmapped byte gives
//   one flagged transfer, and LF right after CR gives none.
//   Path: a taken byte is first held in the event sequencer, whose events
//   are then registered in the output register. Throughput: one event per
//   cycle from the event sequencer while the receiver does not stall; the
//   next byte is taken in the cycle the current one issues its last event.
//   The CR flag lives in a one-entry RAM, read every cycle, with the last
//   write forwarded and a valid bit standing in for a cleared entry.
//   Reset clears the output register, the sequencer and the CR flag.
//   When the receiver stalls the output register holds; the sequencer and
//   then the slave side back up behind it.
// ----------------------------------------------------------------------------
module ascii_to_hid_keystroke_encoder_unit
    import a2hke_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] text_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] key_usage
    output logic [1:0] o_m_axis_tuser,   // [0] key_down, [1] bad_character
    output logic       o_m_axis_tlast    // last_of_run
);

    localparam int AW = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;

    logic                   ram_we;
    logic [STATE_WIDTH-1:0] ram_wdata;
    logic [STATE_WIDTH-1:0] ram_rdata;

    logic                   r_st_vld;
    logic                   r_fwd_vld;
    logic [STATE_WIDTH-1:0] r_fwd_data;

    logic       r_busy, n_busy;
    logic [1:0] r_idx, n_idx;
    logic [7:0] r_usage, n_usage;
    logic       r_shift, n_shift;
    logic       r_bad, n_bad;

    logic       r_out_vld;
    logic [7:0] r_out_usage;
    logic       r_out_down;
    logic       r_out_bad;
    logic       r_out_last;

    logic       in_acc;
    logic       prev_cr;
    logic       drop;
    t_map       map;
    logic       out_load;
    logic       emit;
    logic [7:0] ev_usage;
    logic       ev_down;
    logic       ev_last;

    a2hke_ram #(
        .WIDTH (STATE_WIDTH),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(0)),
        .i_wdata (ram_wdata),
        .i_raddr (AW'(0)),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        priority if (!r_st_vld) begin
            prev_cr = 1'b0;
        end else if (r_fwd_vld) begin
            prev_cr = r_fwd_data[0];
        end else begin
            prev_cr = ram_rdata[0];
        end
    end

    assign out_load        = !r_out_vld || i_m_axis_tready;
    assign emit            = r_busy && out_load;
    assign o_s_axis_tready = !r_busy || (out_load && ev_last);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign drop            = (i_s_axis_tdata == CHR_LF) && prev_cr;
    assign map             = map_byte(i_s_axis_tdata);
    assign ram_we          = in_acc;
    assign ram_wdata       = STATE_WIDTH'(i_s_axis_tdata == CHR_CR);

    always_comb begin
        ev_usage = r_usage;
        ev_down  = 1'b1;
        ev_last  = 1'b0;
        priority if (r_bad) begin
            ev_usage = USAGE_NONE;
            ev_down  = 1'b0;
            ev_last  = 1'b1;
        end else if (r_shift) begin
            unique case (r_idx)
                2'd0: begin ev_usage = USAGE_LEFT_SHIFT; end
                2'd1: begin ev_usage = r_usage; end
                2'd2: begin ev_down = 1'b0; end
                2'd3: begin
                    ev_usage = USAGE_LEFT_SHIFT;
                    ev_down  = 1'b0;
                    ev_last  = 1'b1;
                end
                default: ;
            endcase
        end else begin
            ev_down = (r_idx == 2'd0);
            ev_last = (r_idx != 2'd0);
        end
    end

    always_comb begin
        n_busy  = r_busy;
        n_idx   = r_idx;
        n_usage = r_usage;
        n_shift = r_shift;
        n_bad   = r_bad;
        if (emit) begin
            n_idx = r_idx + 2'd1;
            if (ev_last) begin
                n_busy = 1'b0;
            end
        end
        if (in_acc && !drop) begin
            n_busy  = 1'b1;
            n_idx   = 2'd0;
            n_usage = map.usage;
            n_shift = map.shifted;
            n_bad   = (map.usage == USAGE_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_busy    <= 1'b0;
            r_idx     <= 2'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_st_vld <= 1'b1;
            end
            r_fwd_vld <= in_acc;
            r_busy    <= n_busy;
            r_idx     <= n_idx;
            if (out_load) begin
                r_out_vld <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= ram_wdata;
        r_usage    <= n_usage;
        r_shift    <= n_shift;
        r_bad      <= n_bad;
        if (emit) begin
            r_out_usage <= ev_usage;
            r_out_down  <= ev_down;
            r_out_bad   <= r_bad;
            r_out_last  <= ev_last;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_usage;
    assign o_m_axis_tuser  = {r_out_bad, r_out_down};
    assign o_m_axis_tlast  = r_out_last;

endmodule

FILE: rtl/a2hke_checker.sv
// ----------------------------------------------------------------------------
// a2hke_checker
// Port-level checks on the keystroke encoder, bound to the top level.
// ----------------------------------------------------------------------------
module a2hke_checker
    import a2hke_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [1:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled transfer changed");

    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |->
            o_m_axis_tlast && !o_m_axis_tuser[0] && (o_m_axis_tdata == USAGE_NONE))
        else $error("malformed error event");

    a_shift_up_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata == USAGE_LEFT_SHIFT) && !o_m_axis_tuser[0]
        |-> o_m_axis_tlast)
        else $error("shift release not last");

    a_press_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> !o_m_axis_tlast)
        else $error("press event marked last");

endmodule

bind ascii_to_hid_keystroke_encoder_unit a2hke_checker u_a2hke_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

FILE: tb/ascii_to_hid_keystroke_encoder_unit_test.sv
// ----------------------------------------------------------------------------
// ascii_to_hid_keystroke_encoder_unit_test
// Self-checking bench for the text-to-keystroke encoder. A short opening
// text covers the byte extremes, every key class and the CR/LF handling.
// Random text follows: mostly printable characters and CR LF pairs, with
// some control and high bytes mixed in. Four idling phases run in turn:
// no idling, sender gaps, receiver stalls, and both. A scoreboard predicts
// the press/release events for each accepted byte and compares every event
// the block emits, field by field.
// ----------------------------------------------------------------------------
module ascii_to_hid_keystroke_encoder_unit_test;
    import a2hke_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [7:0] usage;
        logic       down;
        logic       bad;
        logic       last;
    } t_key_event;

    class keystroke_scoreboard;
        t_key_event pending_keys[$];
        logic       after_return;
        int         mismatches;
        int         events_seen;
        int         bytes_taken;
        int         bad_bytes;
        int         swallowed_lf;

        function new();
            after_return = 1'b0;
            mismatches   = 0;
            events_seen  = 0;
            bytes_taken  = 0;
            bad_bytes    = 0;
            swallowed_lf = 0;
        endfunction

        function void lookup_key(input logic [7:0] ch, output logic [7:0] code,
                                 output logic shift);
            code  = USAGE_NONE;
            shift = 1'b0;
            if (ch >= 8'h61 && ch <= 8'h7A) begin
                code = USAGE_A + (ch - 8'h61);
            end else if (ch >= 8'h41 && ch <= 8'h5A) begin
                code  = USAGE_A + (ch - 8'h41);
                shift = 1'b1;
            end else if (ch >= 8'h31 && ch <= 8'h39) begin
                code = USAGE_1 + (ch - 8'h31);
            end else begin
                case (ch)
                    8'h30:          code = USAGE_0;
                    CHR_LF, CHR_CR: code = USAGE_ENTER;
                    8'h09:          code = USAGE_TAB;
                    8'h20:          code = USAGE_SPACE;
                    8'h2D:          code = USAGE_MINUS;
                    8'h3D:          code = 8'h2E;
                    8'h5B:          code = 8'h2F;
                    8'h5D:          code = 8'h30;
                    8'h5C:          code = 8'h31;
                    8'h3B:          code = 8'h33;
                    8'h27:          code = 8'h34;
                    8'h60:          code = 8'h35;
                    8'h2C:          code = 8'h36;
                    8'h2E:          code = 8'h37;
                    8'h2F:          code = USAGE_SLASH;
                    default:        code = USAGE_NONE;
                endcase
                if (code == USAGE_NONE) begin
                    shift = 1'b1;
                    case (ch)
                        8'h5F:   code = USAGE_MINUS;
                        8'h2B:   code = 8'h2E;
                        8'h7B:   code = 8'h2F;
                        8'h7D:   code = 8'h30;
                        8'h7C:   code = 8'h31;
                        8'h3A:   code = 8'h33;
                        8'h22:   code = 8'h34;
                        8'h7E:   code = 8'h35;
                        8'h3C:   code = 8'h36;
                        8'h3E:   code = 8'h37;
                        8'h3F:   code = USAGE_SLASH;
                        8'h21:   code = USAGE_1;
                        8'h40:   code = 8'h1F;
                        8'h23:   code = 8'h20;
                        8'h24:   code = 8'h21;
                        8'h25:   code = 8'h22;
                        8'h5E:   code = 8'h23;
                        8'h26:   code = 8'h24;
                        8'h2A:   code = 8'h25;
                        8'h28:   code = 8'h26;
                        8'h29:   code = USAGE_0;
                        default: begin
                            code  = USAGE_NONE;
                            shift = 1'b0;
                        end
                    endcase
                end
            end
        endfunction

        function void push_key(logic [7:0] usage, logic down, logic bad, logic last);
            t_key_event ev;
            ev.usage = usage;
            ev.down  = down;
            ev.bad   = bad;
            ev.last  = last;
            pending_keys.insert(pending_keys.size(), ev);
        endfunction

        function void note_byte(logic [7:0] ch);
            logic [7:0] code;
            logic       shift;
            bytes_taken++;
            // drop LF right after CR so CR LF types one Enter
            if (ch == CHR_LF && after_return) begin
                after_return = 1'b0;
                swallowed_lf++;
                return;
            end
            after_return = (ch == CHR_CR);
            lookup_key(ch, code, shift);
            if (code == USAGE_NONE) begin
                bad_bytes++;
                push_key(USAGE_NONE, 1'b0, 1'b1, 1'b1);
                return;
            end
            if (shift) push_key(USAGE_LEFT_SHIFT, 1'b1, 1'b0, 1'b0);
            push_key(code, 1'b1, 1'b0, 1'b0);
            push_key(code, 1'b0, 1'b0, !shift);
            if (shift) push_key(USAGE_LEFT_SHIFT, 1'b0, 1'b0, 1'b1);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 40) $display("error at %0t: %s", $time, what);
        endtask

        task check_event(logic [7:0] usage, logic down, logic bad, logic last);
            t_key_event want;
            events_seen++;
            if (pending_keys.size() == 0) begin
                report($sformatf("unexpected event, usage %02h", usage));
                return;
            end
            want = pending_keys.pop_front();
            if (usage !== want.usage)
                report($sformatf("usage %02h, want %02h", usage, want.usage));
            if (down !== want.down)
                report($sformatf("key_down %b, want %b (usage %02h)", down, want.down,
                                 want.usage));
            if (bad !== want.bad)
                report($sformatf("bad_character %b, want %b (usage %02h)", bad, want.bad,
                                 want.usage));
            if (last !== want.last)
                report($sformatf("last %b, want %b (usage %02h)", last, want.last,
                                 want.usage));
        endtask
    endclass

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata  = 8'h00;   // [7:0] text_byte
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;            // [7:0] key_usage
    logic [1:0] o_m_axis_tuser;            // [0] key_down, [1] bad_character
    logic       o_m_axis_tlast;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int cycle_count = 0;

    keystroke_scoreboard board = new();

    logic [7:0] opening_text [27] = '{
        8'h00, 8'hFF, 8'h80, 8'h7F, 8'h61, 8'h7A, 8'h41, 8'h5A, 8'h30,
        8'h31, 8'h39, 8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0A, 8'h0D, 8'h0D,
        8'h0A, 8'h5F, 8'h21, 8'h29, 8'h7E, 8'h5C, 8'h0D, 8'hFF, 8'h0A
    };

    ascii_to_hid_keystroke_encoder_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_event(o_m_axis_tdata, o_m_axis_tuser[0], o_m_axis_tuser[1],
                              o_m_axis_tlast);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("ascii_to_hid_keystroke_encoder_unit: mismatch");
            $finish;
        end
    end

    task type_byte(logic [7:0] ch);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        forever begin
            @(posedge i_clk);
            if (o_s_axis_tready) break;
        end
        board.note_byte(ch);
    endtask

    task random_text(int count);
        int sent;
        int pick;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                type_byte(8'($urandom_range(8'h7E, 8'h20)));
                sent++;
            end else if (pick < 65) begin
                type_byte(CHR_CR);
                type_byte(CHR_LF);
                sent += 2;
            end else if (pick < 75) begin
                type_byte($urandom_range(1) ? CHR_CR : CHR_LF);
                sent++;
            end else if (pick < 85) begin
                type_byte(8'($urandom_range(8'h1F, 8'h00)));
                sent++;
            end else begin
                type_byte(8'($urandom_range(8'hFF, 8'h7F)));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_text[k]) type_byte(opening_text[k]);
        random_text(18);

        sender_idle_pct    = 72;
        receiver_stall_pct = 0;
        random_text(18);

        sender_idle_pct    = 0;
        receiver_stall_pct = 72;
        random_text(18);

        sender_idle_pct    = 26;
        receiver_stall_pct = 26;
        random_text(18);

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (board.pending_keys.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("typed %0d bytes (%0d unmapped, %0d LF after CR), checked %0d key events",
                 board.bytes_taken, board.bad_bytes, board.swallowed_lf, board.events_seen);
        $display("idling phases: none, sender 72%%, receiver 72%%, both 26%%");
        if (board.mismatches == 0 && board.pending_keys.size() == 0) begin
            $display("ascii_to_hid_keystroke_encoder_unit: match");
        end else begin
            $display("ascii_to_hid_keystroke_encoder_unit: mismatch");
        end
        $finish;
    end

endmodule
